[sv/twwbc_pkg.sv]
// ----------------------------------------------------------------------------
// twwbc_pkg
// Shared sizes, codes and helper functions of the two-way write-back cache.
// ----------------------------------------------------------------------------
package twwbc_pkg;

  localparam int SETS       = 1024;
  localparam int WAYS       = 2;
  localparam int LINE_BYTES = 64;
  localparam int BEATS      = LINE_BYTES / 8;
  localparam int SET_W      = $clog2(SETS);
  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int BEAT_W     = $clog2(BEATS);
  localparam int LINE_W     = 32 - OFF_W;
  localparam int TAG_W      = LINE_W - SET_W;
  localparam int WORD_W     = SET_W + 1 + BEAT_W;
  localparam int WORDS      = SETS * WAYS * BEATS;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_FREQ = 2'd1;
  localparam logic [1:0] KIND_WB   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_VICTIM = 2'd1,
    PH_LINE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic                       lru;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][TAG_W-1:0] tag;
  } tag_row_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [25:0] line_address;
    logic [63:0] data;
    logic        last;
    logic [63:0] hit_count;
    logic [63:0] access_count;
  } result_t;

  function automatic logic [3:0] sat_count(input logic [3:0] bc);
    logic [3:0] c;
    c = bc;
    if (bc == 4'd0) c = 4'd1;
    if (bc > 4'd8) c = 4'd8;
    return c;
  endfunction

  function automatic logic [7:0] count_bytes(input logic [3:0] cnt);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) m[i] = (4'(i) < cnt);
    return m;
  endfunction

  function automatic logic [63:0] count_bits(input logic [3:0] cnt);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) m[i*8 +: 8] = (4'(i) < cnt) ? 8'hFF : 8'h00;
    return m;
  endfunction

endpackage

[sv/twwbc_if.sv]
// ----------------------------------------------------------------------------
// twwbc_in_if / twwbc_out_if
// Valid-ready channels carrying cache requests and cache results.
// ----------------------------------------------------------------------------
interface twwbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] address;
  logic [3:0]  byte_count;
  logic [63:0] write_data;
  logic [63:0] fill_data;

  modport source(output valid, op, address, byte_count, write_data, fill_data,
                 input ready);
  modport sink(input valid, op, address, byte_count, write_data, fill_data,
               output ready);
endinterface

interface twwbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [25:0] line_address;
  logic [63:0] data;
  logic        last;
  logic [63:0] hit_count;
  logic [63:0] access_count;

  modport source(output valid, kind, line_address, data, last, hit_count, access_count,
                 input ready);
  modport sink(input valid, kind, line_address, data, last, hit_count, access_count,
               output ready);
endinterface

[sv/two_way_writeback_cache.sv]
// ----------------------------------------------------------------------------
// two_way_writeback_cache
// Two-way set-associative write-back cache with per-byte valid masks.
// ----------------------------------------------------------------------------
// A transaction on req is a read, a write or a fill beat; results leave on rsp
// through an output register, so a new request is taken while a result waits.
// A hit reads tag and masks, then updates them; a write spanning two line
// words adds S_WR_HI, and a read adds S_RD_LO, S_RD_HI and S_RD_OUT for the
// line word reads. Every result waits for a free output register, and each
// writeback beat is read in S_WB_RD, then sent in S_WB_OUT. Tags, masks and
// line data sit in memories with a registered read. After reset the tag
// memory is cleared one set per cycle; no request is taken until it is clear.
module two_way_writeback_cache (
  input  logic               clk,
  input  logic               rst,
  twwbc_in_if.sink           req,
  twwbc_out_if.source        rsp
);
  import twwbc_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_LOOK   = 11'b00000000100,
    S_WR_HI  = 11'b00000001000,
    S_RD_LO  = 11'b00000010000,
    S_RD_HI  = 11'b00000100000,
    S_RD_OUT = 11'b00001000000,
    S_WB_RD  = 11'b00010000000,
    S_WB_OUT = 11'b00100000000,
    S_ALLOC  = 11'b01000000000,
    S_FREQ   = 11'b10000000000
  } state_t;

  state_t state;
  phase_t phase;
  logic [SET_W:0]  clr;
  logic [31:0]     addr;
  logic [63:0]     sdata;
  logic [3:0]      cnt;
  logic            is_write;
  logic            pway;
  logic [BEAT_W-1:0] beat;
  logic [BEAT_W-1:0] wbk;
  logic [63:0]     pmask;
  tag_row_t        trow;
  logic [LINE_W-1:0] freq_line;
  logic [63:0]     rlo;
  logic [63:0]     hits;
  logic [63:0]     accs;
  result_t         out_q;
  logic            out_v;
  logic            out_load;

  tag_row_t   tag_mem [SETS];
  logic [63:0] mask0_mem [SETS];
  logic [63:0] mask1_mem [SETS];
  logic [7:0][7:0] line_mem [WORDS];

  tag_row_t tq;
  logic [63:0] m0q, m1q;
  logic [63:0] line_q;

  logic            tag_we, rd_en;
  logic [SET_W-1:0] tag_wa, rd_a;
  tag_row_t        tag_wd;
  logic [1:0]      mask_we;
  logic [63:0]     mask_wd;
  logic            line_we, line_re;
  logic [WORD_W-1:0] line_wa, line_ra;
  logic [7:0]      line_be;
  logic [63:0]     line_wd;

  logic [SET_W-1:0]  set_a;
  logic [TAG_W-1:0]  tag_a;
  logic [BEAT_W-1:0] obeat;
  logic [2:0]        obyte;
  logic [15:0]       mask16;
  logic [63:0]       reqm;
  logic [127:0]      sh;
  logic              hi_need;
  logic              acc_go, fill_go, out_free;
  logic              hit0, hit1, hit, hw, vict;
  logic [63:0]       mh, mv;
  logic [127:0]      win;

  assign set_a   = addr[OFF_W +: SET_W];
  assign tag_a   = addr[31 -: TAG_W];
  assign obeat   = addr[OFF_W-1:3];
  assign obyte   = addr[2:0];
  assign mask16  = 16'(count_bytes(cnt)) << obyte;
  assign reqm    = 64'(mask16) << {obeat, 3'b000};
  assign sh      = {64'd0, sdata} << {obyte, 3'b000};
  assign hi_need = (obeat != BEAT_W'(BEATS - 1)) && (mask16[15:8] != 8'd0);

  assign req.ready = (state == S_IDLE);
  assign acc_go  = req.valid && req.ready && (req.op == OP_READ || req.op == OP_WRITE)
                   && (phase == PH_IDLE);
  assign fill_go = req.valid && req.ready && (req.op == OP_FILL) && (phase != PH_IDLE);
  assign out_free = !out_v || rsp.ready;
  assign out_load = out_free && (state == S_RD_OUT || state == S_WB_OUT || state == S_FREQ);

  assign hit0 = tq.valid[0] && (tq.tag[0] == tag_a);
  assign hit1 = tq.valid[1] && (tq.tag[1] == tag_a);
  assign hit  = hit0 || hit1;
  assign hw   = !hit0;
  assign mh   = hw ? m1q : m0q;
  assign vict = tq.valid[1] ? !tq.lru : 1'b1;
  assign mv   = vict ? m1q : m0q;
  assign win  = {(obeat == BEAT_W'(BEATS - 1)) ? 64'd0 : line_q, rlo} >> {obyte, 3'b000};

  always_comb begin
    rd_en   = acc_go;
    rd_a    = req.address[OFF_W +: SET_W];
    tag_we  = 1'b0;
    tag_wa  = set_a;
    tag_wd  = trow;
    mask_we = 2'b00;
    mask_wd = 64'd0;
    line_we = 1'b0;
    line_wa = {set_a, pway, obeat};
    line_be = mask16[7:0];
    line_wd = sh[63:0];
    line_re = 1'b0;
    line_ra = {set_a, pway, obeat};
    unique case (state)
      S_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = clr[SET_W-1:0];
        tag_wd = '0;
      end
      S_IDLE: begin
        if (fill_go) begin
          line_we = 1'b1;
          line_wa = {set_a, pway, beat};
          line_be = ~pmask[{beat, 3'b000} +: 8];
          line_wd = req.fill_data;
          if (beat == BEAT_W'(BEATS - 1)) begin
            mask_we[pway] = 1'b1;
            mask_wd       = '1;
          end
        end
      end
      S_LOOK: begin
        if (hit) begin
          tag_we           = 1'b1;
          tag_wd           = tq;
          tag_wd.lru       = hw;
          tag_wd.dirty[hw] = tq.dirty[hw] | is_write;
          if (is_write) begin
            line_we     = 1'b1;
            line_wa     = {set_a, hw, obeat};
            mask_we[hw] = 1'b1;
            mask_wd     = mh | reqm;
          end
        end
      end
      S_ALLOC: begin
        tag_we             = 1'b1;
        tag_wd.tag[pway]   = tag_a;
        tag_wd.valid[pway] = 1'b1;
        tag_wd.dirty[pway] = is_write;
        tag_wd.lru         = pway;
        mask_we[pway]      = 1'b1;
        mask_wd            = is_write ? reqm : 64'd0;
        line_we            = is_write;
      end
      S_WR_HI: begin
        line_we = 1'b1;
        line_wa = {set_a, pway, obeat + 1'b1};
        line_be = mask16[15:8];
        line_wd = sh[127:64];
      end
      S_RD_LO: line_re = 1'b1;
      S_RD_HI: begin
        line_re = 1'b1;
        line_ra = {set_a, pway, obeat + 1'b1};
      end
      S_WB_RD: begin
        line_re = 1'b1;
        line_ra = {set_a, pway, wbk};
      end
      S_RD_OUT, S_WB_OUT, S_FREQ: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (rd_en) tq <= tag_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (mask_we[0]) mask0_mem[set_a] <= mask_wd;
    if (mask_we[1]) mask1_mem[set_a] <= mask_wd;
    if (rd_en) begin
      m0q <= mask0_mem[rd_a];
      m1q <= mask1_mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      for (int i = 0; i < 8; i++) begin
        if (line_be[i]) line_mem[line_wa][i] <= line_wd[i*8 +: 8];
      end
    end
    if (line_re) line_q <= line_mem[line_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= PH_IDLE;
      clr   <= '0;
      beat  <= '0;
      wbk   <= '0;
      hits  <= '0;
      accs  <= '0;
      out_v <= 1'b0;
    end else begin
      if (out_load) out_v <= 1'b1;
      else if (out_v && rsp.ready) out_v <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (SET_W+1)'(SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (acc_go) begin
            addr     <= req.address;
            sdata    <= req.write_data;
            cnt      <= sat_count(req.byte_count);
            is_write <= (req.op == OP_WRITE);
            state    <= S_LOOK;
          end else if (fill_go) begin
            beat <= beat + 1'b1;
            if (beat == BEAT_W'(BEATS - 1)) begin
              pmask <= '1;
              if (phase == PH_LINE) begin
                phase <= PH_IDLE;
                state <= S_RD_LO;
              end else begin
                wbk   <= '0;
                state <= S_WB_RD;
              end
            end
          end
        end
        S_LOOK: begin
          accs <= accs + 64'd1;
          trow <= tq;
          if (hit) begin
            hits <= hits + 64'd1;
            pway <= hw;
            if (is_write) begin
              state <= hi_need ? S_WR_HI : S_IDLE;
            end else if ((mh & reqm) == reqm) begin
              state <= S_RD_LO;
            end else begin
              pmask     <= mh;
              phase     <= PH_LINE;
              beat      <= '0;
              freq_line <= addr[31:OFF_W];
              state     <= S_FREQ;
            end
          end else begin
            pway <= vict;
            if (tq.valid[vict] && tq.dirty[vict]) begin
              if (mv != '1) begin
                pmask     <= mv;
                phase     <= PH_VICTIM;
                beat      <= '0;
                freq_line <= {tq.tag[vict], set_a};
                state     <= S_FREQ;
              end else begin
                wbk   <= '0;
                state <= S_WB_RD;
              end
            end else begin
              state <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          trow <= tag_wd;
          if (is_write) begin
            phase <= PH_IDLE;
            state <= hi_need ? S_WR_HI : S_IDLE;
          end else begin
            pmask     <= '0;
            phase     <= PH_LINE;
            beat      <= '0;
            freq_line <= addr[31:OFF_W];
            state     <= S_FREQ;
          end
        end
        S_WR_HI: state <= S_IDLE;
        S_RD_LO: state <= S_RD_HI;
        S_RD_HI: begin
          rlo   <= line_q;
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (out_free) begin
            out_q.kind         <= KIND_DATA;
            out_q.line_address <= '0;
            out_q.data         <= win[63:0] & count_bits(cnt);
            out_q.last         <= 1'b1;
            out_q.hit_count    <= hits;
            out_q.access_count <= accs;
            state              <= S_IDLE;
          end
        end
        S_WB_RD: state <= S_WB_OUT;
        S_WB_OUT: begin
          if (out_free) begin
            out_q.kind         <= KIND_WB;
            out_q.line_address <= {trow.tag[pway], set_a};
            out_q.data         <= line_q;
            out_q.last         <= (wbk == BEAT_W'(BEATS - 1)) && is_write;
            out_q.hit_count    <= hits;
            out_q.access_count <= accs;
            wbk                <= wbk + 1'b1;
            state              <= (wbk == BEAT_W'(BEATS - 1)) ? S_ALLOC : S_WB_RD;
          end
        end
        S_FREQ: begin
          if (out_free) begin
            out_q.kind         <= KIND_FREQ;
            out_q.line_address <= freq_line;
            out_q.data         <= '0;
            out_q.last         <= 1'b1;
            out_q.hit_count    <= hits;
            out_q.access_count <= accs;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_v;
  assign rsp.kind         = out_q.kind;
  assign rsp.line_address = out_q.line_address;
  assign rsp.data         = out_q.data;
  assign rsp.last         = out_q.last;
  assign rsp.hit_count    = out_q.hit_count;
  assign rsp.access_count = out_q.access_count;

  a_look_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |-> phase == PH_IDLE) else $error("lookup while a fill is pending");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |=> accs == $past(accs) + 64'd1) else $error("access count slipped");

  a_beat_phase: assert property (@(posedge clk) disable iff (rst)
    beat != '0 |-> phase != PH_IDLE) else $error("fill beats counted while idle");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_v) else $error("result during clearing pass");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives reads, writes and fill beats into the two-way write-back cache and
// compares every result transaction against a cycle-free model of the cache
// that tracks tags, LRU bits, line bytes, byte valid masks and the counters.
// ----------------------------------------------------------------------------
module testbench;
  import twwbc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  twwbc_in_if  req();
  twwbc_out_if rsp();

  two_way_writeback_cache uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #5 clk = ~clk;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] address;
    logic [3:0]  byte_count;
    logic [63:0] write_data;
    logic        typed;
    result_t     want;
  } row_t;

  logic [TAG_W-1:0] tags [SETS][WAYS];
  bit               way_vld [SETS][WAYS];
  bit               way_drt [SETS][WAYS];
  logic [7:0]       bytes [SETS][WAYS][LINE_BYTES];
  logic [63:0]      vmask [SETS][WAYS];
  bit               lru [SETS];
  logic [63:0]      hits, accesses;
  logic [31:0]      pend_addr;
  logic [63:0]      pend_data;
  phase_t           phase;
  int               beat_idx, pend_cnt;
  bit               pend_way, pend_write;

  result_t expected_q[$];
  int      errors = 0;
  int      cycles = 0;
  bit      idle_ok = 1'b1;
  int      stall_left = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  task automatic push_result(input logic [1:0] k, input logic [31:0] la,
                             input logic [63:0] d);
    result_t r;
    r.kind = k;
    r.line_address = la[25:0];
    r.data = d;
    r.last = 1'b0;
    r.hit_count = hits;
    r.access_count = accesses;
    expected_q.push_back(r);
  endtask

  function automatic logic [31:0] line_num(input int s, input int w);
    return 32'({tags[s][w], 10'(s)});
  endfunction

  function automatic logic [63:0] gather(input int s, input int w, input int off,
                                         input int cnt);
    logic [63:0] v;
    v = '0;
    for (int b = 0; b < cnt && b < 8; b++)
      if (off + b < LINE_BYTES) v[8*b +: 8] = bytes[s][w][off + b];
    return v;
  endfunction

  task automatic push_writeback(input int s, input int w);
    for (int k = 0; k < BEATS; k++) push_result(KIND_WB, line_num(s, w), gather(s, w, k*8, 8));
  endtask

  task automatic store_bytes(input int s, input int w, input int off, input int cnt,
                             input logic [63:0] d);
    for (int b = 0; b < cnt && b < 8; b++)
      if (off + b < LINE_BYTES) begin
        bytes[s][w][off + b] = d[8*b +: 8];
        vmask[s][w][off + b] = 1'b1;
      end
    way_drt[s][w] = 1'b1;
  endtask

  task automatic allocate_pending();
    int s, off, w;
    s = pend_addr[15:6];
    off = pend_addr[5:0];
    w = pend_way;
    tags[s][w] = pend_addr[31:16];
    way_vld[s][w] = 1'b1;
    way_drt[s][w] = 1'b0;
    vmask[s][w] = '0;
    if (pend_write) begin
      store_bytes(s, w, off, pend_cnt, pend_data);
      phase = PH_IDLE;
    end else begin
      push_result(KIND_FREQ, {6'd0, pend_addr[31:6]}, '0);
      phase = PH_LINE;
      beat_idx = 0;
    end
  endtask

  task automatic cache_access(input logic [1:0] op, input logic [31:0] a,
                              input logic [3:0] bc, input logic [63:0] wd);
    int s, off, cnt, w;
    logic [63:0] need;
    s = a[15:6];
    off = a[5:0];
    cnt = bc;
    if (cnt < 1) cnt = 1;
    if (cnt > 8) cnt = 8;
    if (cnt > LINE_BYTES - off) cnt = LINE_BYTES - off;
    accesses++;
    pend_addr = a;
    pend_data = wd;
    pend_cnt = cnt;
    pend_write = (op == OP_WRITE);
    for (w = 0; w < WAYS; w++)
      if (way_vld[s][w] && tags[s][w] == a[31:16]) begin
        hits++;
        lru[s] = 1'(w);
        if (pend_write) begin
          store_bytes(s, w, off, cnt, wd);
          return;
        end
        need = '0;
        for (int b = 0; b < cnt; b++) need[off + b] = 1'b1;
        if ((vmask[s][w] & need) == need) begin
          push_result(KIND_DATA, '0, gather(s, w, off, cnt));
          return;
        end
        pend_way = 1'(w);
        phase = PH_LINE;
        beat_idx = 0;
        push_result(KIND_FREQ, {6'd0, a[31:6]}, '0);
        return;
      end
    w = way_vld[s][1] ? 1 - lru[s] : 1;
    lru[s] = 1'(w);
    pend_way = 1'(w);
    if (way_vld[s][w] && way_drt[s][w]) begin
      if (vmask[s][w] != '1) begin
        phase = PH_VICTIM;
        beat_idx = 0;
        push_result(KIND_FREQ, line_num(s, w), '0);
        return;
      end
      push_writeback(s, w);
    end
    allocate_pending();
  endtask

  task automatic fill_beat(input logic [63:0] fd);
    int s, w;
    s = pend_addr[15:6];
    w = pend_way;
    if (phase == PH_IDLE) return;
    for (int b = 0; b < 8; b++)
      if (!vmask[s][w][beat_idx*8 + b]) bytes[s][w][beat_idx*8 + b] = fd[8*b +: 8];
    beat_idx++;
    if (beat_idx < BEATS) return;
    beat_idx = 0;
    vmask[s][w] = '1;
    if (phase == PH_VICTIM) begin
      push_writeback(s, w);
      allocate_pending();
      return;
    end
    phase = PH_IDLE;
    push_result(KIND_DATA, '0, gather(s, w, pend_addr[5:0], pend_cnt));
  endtask

  task automatic predict(input logic [1:0] op, input logic [31:0] a, input logic [3:0] bc,
                         input logic [63:0] wd, input logic [63:0] fd);
    int start;
    start = expected_q.size();
    if (op == OP_READ || op == OP_WRITE) begin
      if (phase == PH_IDLE) cache_access(op, a, bc, wd);
    end else if (op == OP_FILL) begin
      fill_beat(fd);
    end
    if (expected_q.size() > start) expected_q[$].last = 1'b1;
  endtask

  task automatic send(input logic [1:0] op, input logic [31:0] a, input logic [3:0] bc,
                      input logic [63:0] wd, input logic [63:0] fd);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.address <= a;
    req.byte_count <= bc;
    req.write_data <= wd;
    req.fill_data <= fd;
    do @(posedge clk); while (!req.ready);
    predict(op, a, bc, wd, fd);
  endtask

  task automatic send_fills();
    while (phase != PH_IDLE)
      send(OP_FILL, $urandom, 4'($urandom), {$urandom, $urandom},
           {$urandom, $urandom});
  endtask

  function automatic logic [31:0] rand_addr();
    logic [15:0] tg;
    logic [9:0]  st;
    logic [5:0]  off;
    case ($urandom_range(0, 4))
      0: tg = 16'hFFFF;
      1: tg = 16'($urandom);
      default: tg = 16'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 3))
      0: st = 10'h3FF;
      1: st = 10'($urandom);
      default: st = 10'($urandom_range(0, 2));
    endcase
    off = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(56, 63)) : 6'($urandom);
    return {tg, st, off};
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (rsp.kind != e.kind)
            report($sformatf("kind %0d, want %0d", rsp.kind, e.kind));
          if (rsp.line_address != e.line_address)
            report($sformatf("line_address %h, want %h", rsp.line_address, e.line_address));
          if (rsp.data != e.data)
            report($sformatf("data %h, want %h", rsp.data, e.data));
          if (rsp.last != e.last)
            report($sformatf("last %b, want %b", rsp.last, e.last));
          if (rsp.hit_count != e.hit_count)
            report($sformatf("hit_count %0d, want %0d", rsp.hit_count, e.hit_count));
          if (rsp.access_count != e.access_count)
            report($sformatf("access_count %0d, want %0d", rsp.access_count,
                             e.access_count));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        if (stall_left == 1) rsp.ready <= 1'b1;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 9);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int   roll;
    logic [1:0] op;

    req.valid <= 1'b0;
    req.op <= OP_READ;
    req.address <= '0;
    req.byte_count <= '0;
    req.write_data <= '0;
    req.fill_data <= '0;

    foreach (way_vld[s, w]) begin
      way_vld[s][w] = 1'b0;
      way_drt[s][w] = 1'b0;
      tags[s][w] = '0;
      vmask[s][w] = '0;
    end
    foreach (lru[s]) lru[s] = 1'b0;
    hits = '0;
    accesses = '0;
    pend_addr = '0;
    pend_data = '0;
    phase = PH_IDLE;
    beat_idx = 0;
    pend_cnt = 0;
    pend_way = 1'b0;
    pend_write = 1'b0;

    r = '{OP_READ, 32'h0, 4'd1, 64'h0, 1'b1,
          '{KIND_FREQ, 26'd0, 64'd0, 1'b1, 64'd0, 64'd1}};
    rows.push_back(r);
    r.typed = 1'b0;
    r.op = OP_WRITE; r.address = 32'hFFFF_FFF8; r.byte_count = 4'd8;
    r.write_data = '1;
    rows.push_back(r);
    r.op = OP_READ; r.address = 32'hFFFF_FFFF; r.byte_count = 4'd15;
    rows.push_back(r);
    r.op = OP_WRITE; r.address = 32'h3F; r.byte_count = 4'd0;
    r.write_data = 64'h0123_4567_89AB_CDEF;
    rows.push_back(r);
    r.op = OP_READ; r.address = 32'h38; r.byte_count = 4'd8;
    rows.push_back(r);
    r.op = 2'd3;
    rows.push_back(r);
    r.op = OP_FILL;
    rows.push_back(r);
    r.op = OP_WRITE; r.address = 32'h1_0000; r.byte_count = 4'd4;
    rows.push_back(r);
    r.address = 32'h2_0000; r.byte_count = 4'd8; r.write_data = 64'h0;
    rows.push_back(r);
    r.address = 32'h3_0000; r.byte_count = 4'd2; r.write_data = 64'hA5A5_5A5A_FFFF_0000;
    rows.push_back(r);
    r.op = OP_READ; r.address = 32'h1_0000; r.byte_count = 4'd8;
    rows.push_back(r);
    r.op = OP_READ; r.address = 32'hFFFF_0008; r.byte_count = 4'd9;
    rows.push_back(r);
    for (int k = 0; k < 8; k++) begin
      r.op = OP_WRITE; r.address = 32'h5_0040 + 32'(k*8); r.byte_count = 4'd8;
      r.write_data = {$urandom, $urandom};
      rows.push_back(r);
    end
    r.address = 32'h6_0040;
    rows.push_back(r);
    r.address = 32'h7_0047; r.byte_count = 4'd1;
    rows.push_back(r);
    r.op = OP_READ; r.address = 32'h7_0040; r.byte_count = 4'd8;
    rows.push_back(r);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send(rows[i].op, rows[i].address, rows[i].byte_count, rows[i].write_data,
           {$urandom, $urandom});
      if (rows[i].typed) expected_q[$] = rows[i].want;
      send_fills();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > RANDOM_ITEMS * 4 / 5) idle_ok = 1'b0;
      roll = $urandom_range(0, 19);
      if (phase != PH_IDLE && roll < 17) op = OP_FILL;
      else if (roll == 19) op = 2'($urandom_range(2, 3));
      else op = (roll % 2) ? OP_WRITE : OP_READ;
      send(op, rand_addr(), 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    end
    send_fills();
    req.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (expected_q.size() != 0) report("expected results left over");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
